[rtl/zero_crossing_symbol_slicer_defines.svh]
// ----------------------------------------------------------------------------
// Zero-crossing symbol slicer assertion macros
// Shared concurrent assertion forms, clocked on clk_i and muted in reset.
// ----------------------------------------------------------------------------
`ifndef ZERO_CROSSING_SYMBOL_SLICER_DEFINES_SVH
`define ZERO_CROSSING_SYMBOL_SLICER_DEFINES_SVH

// consequent must hold in the same cycle
`define ZCSS_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the next cycle
`define ZCSS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/zcss_pkg.sv]
// ----------------------------------------------------------------------------
// Zero-crossing symbol slicer package
// Shared types, register indexes and fixed widths.
// ----------------------------------------------------------------------------
package zcss_pkg;

  localparam int ROT_W        = 16;
  localparam int RATE_W       = 17;
  localparam int RATE_FRAC_W  = 16;
  localparam int COUNT_W      = 24;
  localparam int RUN_W        = 7;   // holds run lengths up to 64
  localparam int CFG_IDX_W    = 8;
  localparam int CFG_DATA_W   = 17;
  localparam int QUEUE_DEPTH  = 2;   // power of two

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [RATE_W-1:0]  RATE_ONE  = RATE_W'(1 << RATE_FRAC_W);

  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ROT_RE = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_ROT_IM = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_RATE   = CFG_IDX_W'(3);

  localparam logic signed [ROT_W-1:0] ROT_RE_RESET = 16'sh7fff;
  localparam logic signed [ROT_W-1:0] ROT_IM_RESET = 16'sh0000;

  typedef enum logic [1:0] {
    MODE_AMP   = 2'd0,
    MODE_PHASE = 2'd1,
    MODE_FREQ  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    SIGN_NONE = 2'd0,
    SIGN_POS  = 2'd1,
    SIGN_NEG  = 2'd2
  } sign_e;

  typedef enum logic [2:0] {
    F_IDLE,
    F_MUL,
    F_DEC,
    F_RUNH,
    F_RUNL,
    F_PUSH
  } front_state_e;

  typedef struct packed {
    logic [1:0]              mode;
    logic signed [ROT_W-1:0] rot_re;
    logic signed [ROT_W-1:0] rot_im;
    logic [RATE_W-1:0]       rate;
  } cfg_t;

  typedef struct packed {
    logic             pos;
    logic             sat;
    logic [RUN_W-1:0] len;
  } run_cmd_t;

endpackage

[rtl/zcss_sample_if.sv]
// ----------------------------------------------------------------------------
// Sample channel
// Valid/ready channel carrying one complex sample and the end-of-data mark.
// ----------------------------------------------------------------------------
interface zcss_sample_if #(
  parameter int SAMPLE_BITS = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_re;
  logic signed [SAMPLE_BITS-1:0] sample_im;
  logic                          end_of_data;

  modport source (output valid, sample_re, sample_im, end_of_data, input ready);
  modport sink   (input valid, sample_re, sample_im, end_of_data, output ready);
endinterface

[rtl/zcss_symbol_if.sv]
// ----------------------------------------------------------------------------
// Symbol channel
// Valid/ready channel carrying one recovered symbol and its run flags.
// ----------------------------------------------------------------------------
interface zcss_symbol_if ();
  logic valid;
  logic ready;
  logic symbol_bit;
  logic last_of_run;
  logic run_saturated;

  modport source (output valid, symbol_bit, last_of_run, run_saturated, input ready);
  modport sink   (input valid, symbol_bit, last_of_run, run_saturated, output ready);
endinterface

[rtl/zcss_cfg_if.sv]
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface zcss_cfg_if
  import zcss_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/zcss_queue.sv]
// ----------------------------------------------------------------------------
// Run command queue
// Small FIFO of run commands between the front and back parts.
// ----------------------------------------------------------------------------
module zcss_queue
  import zcss_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  run_cmd_t data_i,
  output logic     full_o,
  input  logic     pop_i,
  output run_cmd_t data_o,
  output logic     empty_o
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  run_cmd_t         entry_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [PTR_W:0]   cnt_q;

  assign full_o  = (cnt_q == (PTR_W+1)'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

[rtl/zcss_front.sv]
// ----------------------------------------------------------------------------
// Slicer front end
// Takes samples, forms the decision sign, tracks runs and sizes ended runs.
// ----------------------------------------------------------------------------
module zcss_front
  import zcss_pkg::*;
#(
  parameter int SAMPLE_BITS = 16,
  parameter int MAX_RUN     = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  zcss_sample_if.sink sample_i,
  output logic       push_o,
  output run_cmd_t   cmd_o,
  input  logic       full_i
);

  localparam int BW      = (SAMPLE_BITS > ROT_W) ? SAMPLE_BITS : ROT_W;
  localparam int PW      = SAMPLE_BITS + BW;
  localparam int SW      = PW + 1;
  localparam int LO_W    = COUNT_W / 2;
  localparam int HI_W    = COUNT_W - LO_W;
  localparam int PHI_W   = HI_W + RATE_W;
  localparam int PLO_W   = LO_W + RATE_W;
  localparam int TOT_W   = COUNT_W + RATE_W;
  localparam int NS_W    = TOT_W - RATE_FRAC_W;
  localparam logic [TOT_W-1:0] ROUND_HALF = TOT_W'(1) << (RATE_FRAC_W - 1);

  front_state_e state_q, state_d;

  logic signed [SAMPLE_BITS-1:0] x_re_q, x_im_q;
  logic                          eod_q;
  logic signed [PW-1:0]          prod_q [4];
  logic signed [SAMPLE_BITS-1:0] prev_re_q, prev_im_q;
  sign_e                         psign_q;
  logic [COUNT_W-1:0]            count_q;
  logic                          run_pos_q;
  logic [COUNT_W-1:0]            run_cnt_q;
  logic [PHI_W-1:0]              pp_hi_q;
  logic [PLO_W-1:0]              pp_lo_q;
  run_cmd_t                      cmd_q;

  logic                          freq;
  logic signed [BW-1:0]          b_pr, b_pi, b_rr, b_ri;
  logic signed [SAMPLE_BITS-1:0] mul_a [4];
  logic signed [BW-1:0]          mul_b [4];
  logic signed [SW-1:0]          re_v, im_v;
  sign_e                         s;
  logic                          crossing, emit_run;
  logic [RATE_W-1:0]             rate_eff;
  logic [TOT_W-1:0]              total;
  logic [NS_W-1:0]               nsym;
  logic                          sat;

  assign freq = (cfg_i.mode == MODE_FREQ);
  assign b_pr = BW'(prev_re_q);
  assign b_pi = BW'(prev_im_q);
  assign b_rr = BW'(cfg_i.rot_re);
  assign b_ri = BW'(cfg_i.rot_im);

  // lane operands: rotated product, or x times conj(previous) in frequency mode
  always_comb begin
    mul_a[0] = x_re_q;
    mul_b[0] = freq ? b_pr : b_rr;
    mul_a[1] = x_im_q;
    mul_b[1] = freq ? b_pi : b_ri;
    mul_a[2] = freq ? x_im_q : x_re_q;
    mul_b[2] = freq ? b_pr : b_ri;
    mul_a[3] = freq ? x_re_q : x_im_q;
    mul_b[3] = freq ? b_pi : b_rr;
  end

  always_comb begin
    if (freq) begin
      // i*d: real part is -Im(d), imaginary part is Re(d)
      re_v = SW'(prod_q[3]) - SW'(prod_q[2]);
      im_v = SW'(prod_q[0]) + SW'(prod_q[1]);
    end else begin
      re_v = SW'(prod_q[0]) - SW'(prod_q[1]);
      im_v = SW'(prod_q[2]) + SW'(prod_q[3]);
    end
    if (cfg_i.mode == MODE_PHASE || cfg_i.mode == MODE_FREQ) begin
      if (im_v > 0)      s = SIGN_POS;
      else if (im_v < 0) s = SIGN_NEG;
      else if (re_v < 0) s = SIGN_POS;   // argument is +pi
      else               s = SIGN_NONE;
    end else begin
      if (re_v > 0)      s = SIGN_POS;
      else if (re_v < 0) s = SIGN_NEG;
      else               s = SIGN_NONE;
    end
  end

  assign crossing = (s != SIGN_NONE) && (psign_q != SIGN_NONE) && (s != psign_q);
  assign emit_run = eod_q ? (psign_q != SIGN_NONE) : crossing;

  assign rate_eff = (cfg_i.rate > RATE_ONE) ? RATE_ONE : cfg_i.rate;
  assign total    = (TOT_W'(pp_hi_q) << LO_W) + TOT_W'(pp_lo_q) + ROUND_HALF;
  assign nsym     = total[TOT_W-1:RATE_FRAC_W];
  assign sat      = (nsym > NS_W'(MAX_RUN));

  always_comb begin
    state_d        = state_q;
    sample_i.ready = 1'b0;
    push_o         = 1'b0;
    case (state_q)
      F_IDLE: begin
        sample_i.ready = 1'b1;
        if (sample_i.valid) state_d = F_MUL;
      end
      F_MUL:  state_d = F_DEC;
      F_DEC:  state_d = emit_run ? F_RUNH : F_IDLE;
      F_RUNH: state_d = F_RUNL;
      F_RUNL: state_d = F_PUSH;
      F_PUSH: begin
        if (cmd_q.len == '0) begin
          state_d = F_IDLE;
        end else if (!full_i) begin
          push_o  = 1'b1;
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  assign cmd_o = cmd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // run tracking state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_re_q <= '0;
      prev_im_q <= '0;
      psign_q   <= SIGN_NONE;
      count_q   <= '0;
    end else if (state_q == F_DEC) begin
      if (eod_q) begin
        prev_re_q <= '0;
        prev_im_q <= '0;
        psign_q   <= SIGN_NONE;
        count_q   <= '0;
      end else begin
        if (freq) begin
          prev_re_q <= x_re_q;
          prev_im_q <= x_im_q;
        end
        if (crossing) begin
          count_q <= COUNT_W'(1);
        end else if (count_q != COUNT_MAX) begin
          count_q <= count_q + 1'b1;
        end
        if (s != SIGN_NONE) begin
          psign_q <= s;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == F_IDLE && sample_i.valid) begin
      x_re_q <= sample_i.sample_re;
      x_im_q <= sample_i.sample_im;
      eod_q  <= sample_i.end_of_data;
    end
    if (state_q == F_MUL) begin
      for (int k = 0; k < 4; k++) begin
        prod_q[k] <= PW'(mul_a[k]) * PW'(mul_b[k]);
      end
    end
    if (state_q == F_DEC) begin
      run_pos_q <= (psign_q == SIGN_POS);
      run_cnt_q <= count_q;
    end
    if (state_q == F_RUNH) begin
      // count split in halves to keep each product narrow
      pp_hi_q <= PHI_W'(run_cnt_q[COUNT_W-1:LO_W]) * PHI_W'(rate_eff);
      pp_lo_q <= PLO_W'(run_cnt_q[LO_W-1:0]) * PLO_W'(rate_eff);
    end
    if (state_q == F_RUNL) begin
      cmd_q.pos <= run_pos_q;
      cmd_q.sat <= sat;
      cmd_q.len <= sat ? RUN_W'(MAX_RUN) : nsym[RUN_W-1:0];
    end
  end

endmodule

[rtl/zcss_back.sv]
// ----------------------------------------------------------------------------
// Slicer back end
// Expands run commands into symbols through a registered output stage.
// ----------------------------------------------------------------------------
module zcss_back
  import zcss_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  run_cmd_t      head_i,
  input  logic          empty_i,
  output logic          pop_o,
  zcss_symbol_if.source symbol_o
);

  logic             active_q;
  logic [RUN_W-1:0] remaining_q;
  logic             pos_q, sat_q;
  logic             out_valid_q;
  logic             out_bit_q, out_last_q, out_sat_q;
  logic             load;

  assign pop_o = !active_q && !empty_i;
  assign load  = active_q && (!out_valid_q || symbol_o.ready);

  assign symbol_o.valid         = out_valid_q;
  assign symbol_o.symbol_bit    = out_bit_q;
  assign symbol_o.last_of_run   = out_last_q;
  assign symbol_o.run_saturated = out_sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        active_q <= 1'b1;
      end else if (load && remaining_q == RUN_W'(1)) begin
        active_q <= 1'b0;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (symbol_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      remaining_q <= head_i.len;
      pos_q       <= head_i.pos;
      sat_q       <= head_i.sat;
    end else if (load) begin
      remaining_q <= remaining_q - 1'b1;
    end
    if (load) begin
      out_bit_q  <= pos_q;
      out_last_q <= (remaining_q == RUN_W'(1));
      out_sat_q  <= sat_q;
    end
  end

endmodule

[rtl/zero_crossing_symbol_slicer.sv]
// The first symbol of a run leaves the output register after the sample ending it passes
// the front sequencer (register, multiply, decide, then run product, run size and a push
// that waits on a full queue) and the queue; the back end takes each run from the queue,
// then emits 1 symbol per cycle while the output is ready. Reset (async, active low)
// restores the register defaults, clears run state and empties the queue; no clearing pass.
// ----------------------------------------------------------------------------
// Zero-crossing symbol slicer
// Slices complex samples by mode and turns sign runs into binary symbols.
// ----------------------------------------------------------------------------
`include "zero_crossing_symbol_slicer_defines.svh"

module zero_crossing_symbol_slicer
  import zcss_pkg::*;
#(
  parameter int SAMPLE_BITS = 16,
  parameter int MAX_RUN     = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  zcss_cfg_if.sink      cfg_i,
  zcss_sample_if.sink   sample_i,
  zcss_symbol_if.source symbol_o
);

  cfg_t     cfg_q;
  logic     q_push, q_full, q_pop, q_empty;
  run_cmd_t q_in, q_head;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode   <= MODE_AMP;
      cfg_q.rot_re <= ROT_RE_RESET;
      cfg_q.rot_im <= ROT_IM_RESET;
      cfg_q.rate   <= RATE_ONE;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        CFG_MODE:   cfg_q.mode   <= cfg_i.data[1:0];
        CFG_ROT_RE: cfg_q.rot_re <= $signed(cfg_i.data[ROT_W-1:0]);
        CFG_ROT_IM: cfg_q.rot_im <= $signed(cfg_i.data[ROT_W-1:0]);
        CFG_RATE:   cfg_q.rate   <= cfg_i.data[RATE_W-1:0];
        default:    ;
      endcase
    end
  end

  zcss_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_RUN     (MAX_RUN)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .sample_i (sample_i),
    .push_o   (q_push),
    .cmd_o    (q_in),
    .full_i   (q_full)
  );

  zcss_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_head),
    .empty_o (q_empty)
  );

  zcss_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (q_head),
    .empty_i  (q_empty),
    .pop_o    (q_pop),
    .symbol_o (symbol_o)
  );

  `ZCSS_ASSERT_SAME(a_push_has_room, q_push, !q_full, "run request pushed into a full queue")
  `ZCSS_ASSERT_SAME(a_pop_nonempty_run, q_pop, !q_empty && (q_head.len != '0), "empty run popped")
  `ZCSS_ASSERT_NEXT(a_one_sample_in_flight, sample_i.valid && sample_i.ready, !sample_i.ready, "sample taken while busy")

endmodule
